/* src/svpd_pkg.sv */
// ----------------------------------------------------------------------------
// svpd_pkg: shared types and constants for the space vector PWM duty block
// Sector codes, fixed coefficients of the sector tests and time terms, and
// the widths of the result fields.
// ----------------------------------------------------------------------------
package svpd_pkg;

    // Result field widths
    localparam int OUT_W = 14;
    localparam int SEC_W = 3;

    // PWM period and its log2 (time terms are scaled by 1/PERIOD)
    localparam int PERIOD      = 1024;
    localparam int PERIOD_LOG2 = 10;

    // Coefficients: sector boundary test and active-vector time terms
    localparam int K_EDGE  = 1774;
    localparam int K_BETA  = 1024;
    localparam int K_A768  = 768;
    localparam int K_B443  = 443;
    localparam int K_B887  = 887;

    // Sector codes; code 0 is the first sector of the hexagon
    typedef enum logic [SEC_W-1:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

endpackage

/* src/space_vector_pwm_duty_top.sv */
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_top: space vector PWM duty calculator
// Turns an (alpha, beta) voltage request into three centred phase compare
// values and the sector number, for a period of 1024 counts.
// ----------------------------------------------------------------------------
// A request enters the input register and its result is offered from the
// result register: the input register feeds the sector search, the active-time
// division and the compare stacking in one combinational pass, and the result
// register holds the outcome. Both registers advance together under
// back-pressure, so the block sustains one request per cycle while the output
// side is ready; a waiting result holds the input register and with it the
// input. Inputs are taken as IN_WIDTH-bit two's complement; compare values
// wrap to 14 bits and are not saturated when the vector lies outside the
// hexagon.
module space_vector_pwm_duty_top #(
    parameter int IN_WIDTH = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // slave side
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    // [IN_WIDTH-1:0] volt_alpha, [2*IN_WIDTH-1:IN_WIDTH] volt_beta, zero pad
    input  logic [((2*IN_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // master side
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // [13:0] compare_u, [27:14] compare_v, [41:28] compare_w,
    // [44:42] sector_index, [47:45] zero pad
    output logic [47:0]        o_m_tdata
);

    localparam int TW         = IN_WIDTH + 2;
    localparam int CW         = (IN_WIDTH + 4 > svpd_pkg::OUT_W) ?
                                (IN_WIDTH + 4) : svpd_pkg::OUT_W;
    localparam int OW         = svpd_pkg::OUT_W;
    localparam int SW         = svpd_pkg::SEC_W;
    localparam int PAD_W      = 48 - 3*OW - SW;

    // Stage registers
    logic                       r_in_vld;
    logic signed [IN_WIDTH-1:0] r_alpha;
    logic signed [IN_WIDTH-1:0] r_beta;
    logic                       r_out_vld;
    logic [OW-1:0]              r_cmp_u;
    logic [OW-1:0]              r_cmp_v;
    logic [OW-1:0]              r_cmp_w;
    svpd_pkg::t_sector          r_out_sector;

    // Combinational results
    svpd_pkg::t_sector          n_sector;
    logic signed [TW-1:0]       ta_sel;
    logic signed [TW-1:0]       tb_sel;
    logic [OW-1:0]              n_cmp_u;
    logic [OW-1:0]              n_cmp_v;
    logic [OW-1:0]              n_cmp_w;

    logic out_free;
    logic in_free;

    // Stall chain: a stage may load when it is empty or its contents move on
    assign out_free   = !r_out_vld || i_m_tready;
    assign in_free    = !r_in_vld || out_free;
    assign o_s_tready = in_free;

    // Sector and active times
    svpd_times #(
        .IN_WIDTH (IN_WIDTH),
        .TW       (TW)
    ) u_times (
        .i_alpha  (r_alpha),
        .i_beta   (r_beta),
        .o_sector (n_sector),
        .o_ta     (ta_sel),
        .o_tb     (tb_sel)
    );

    // Centred compare values
    svpd_compare #(
        .TW (TW),
        .CW (CW)
    ) u_compare (
        .i_sector (n_sector),
        .i_ta     (ta_sel),
        .i_tb     (tb_sel),
        .o_cmp_u  (n_cmp_u),
        .o_cmp_v  (n_cmp_v),
        .o_cmp_w  (n_cmp_w)
    );

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_vld <= i_s_tvalid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // Payload: hold while the next stage is stalled
    always_ff @(posedge i_clk) begin
        if (in_free) begin
            r_alpha <= i_s_tdata[IN_WIDTH-1:0];
            r_beta  <= i_s_tdata[2*IN_WIDTH-1:IN_WIDTH];
        end
        if (out_free) begin
            r_cmp_u      <= n_cmp_u;
            r_cmp_v      <= n_cmp_v;
            r_cmp_w      <= n_cmp_w;
            r_out_sector <= n_sector;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {PAD_W'(0), r_out_sector, r_cmp_w, r_cmp_v, r_cmp_u};

endmodule

/* src/svpd_times.sv */
// ----------------------------------------------------------------------------
// svpd_times: sector search and active-vector times
// Finds the sector from three sign tests and computes the two active times,
// each divided by the period with truncation toward zero.
// ----------------------------------------------------------------------------
module svpd_times #(
    parameter int IN_WIDTH = 12,
    parameter int TW       = 14
) (
    input  logic signed [IN_WIDTH-1:0] i_alpha,
    input  logic signed [IN_WIDTH-1:0] i_beta,
    output svpd_pkg::t_sector          o_sector,
    output logic signed [TW-1:0]       o_ta,
    output logic signed [TW-1:0]       o_tb
);

    // Product width: input plus the 11-bit coefficients plus a sign bit
    localparam int PW = IN_WIDTH + 12;

    logic signed [PW-1:0] a_x;
    logic signed [PW-1:0] b_x;
    logic signed [PW-1:0] p_edge;
    logic signed [PW-1:0] p_beta;
    logic signed [PW-1:0] p_a768;
    logic signed [PW-1:0] p_b443;
    logic signed [PW-1:0] p_b887;
    logic signed [PW-1:0] s_plus;
    logic signed [PW-1:0] s_minus;
    logic                 b_pos;
    logic                 sp_pos;
    logic                 sm_pos;
    logic signed [PW-1:0] num_a;
    logic signed [PW-1:0] num_b;
    logic signed [PW-1:0] adj_a;
    logic signed [PW-1:0] adj_b;
    logic signed [PW-1:0] quo_a;
    logic signed [PW-1:0] quo_b;

    // Sign-extend and form the constant products
    assign a_x     = PW'(i_alpha);
    assign b_x     = PW'(i_beta);
    assign p_edge  = a_x * PW'(svpd_pkg::K_EDGE);
    assign p_beta  = b_x * PW'(svpd_pkg::K_BETA);
    assign p_a768  = a_x * PW'(svpd_pkg::K_A768);
    assign p_b443  = b_x * PW'(svpd_pkg::K_B443);
    assign p_b887  = b_x * PW'(svpd_pkg::K_B887);
    assign s_plus  = p_edge + p_beta;
    assign s_minus = p_edge - p_beta;

    // Strict positive tests
    assign b_pos  = !i_beta[IN_WIDTH-1] && (i_beta != '0);
    assign sp_pos = !s_plus[PW-1] && (s_plus != '0);
    assign sm_pos = !s_minus[PW-1] && (s_minus != '0);

    // Pick the sector
    always_comb begin
        if (b_pos) begin
            if (sp_pos) begin
                o_sector = sm_pos ? svpd_pkg::SEC_0 : svpd_pkg::SEC_1;
            end else begin
                o_sector = svpd_pkg::SEC_2;
            end
        end else begin
            if (sp_pos) begin
                o_sector = svpd_pkg::SEC_5;
            end else begin
                o_sector = sm_pos ? svpd_pkg::SEC_4 : svpd_pkg::SEC_3;
            end
        end
    end

    // Select the time numerators for the sector
    always_comb begin
        case (o_sector)
            svpd_pkg::SEC_0: begin
                num_a = p_a768 - p_b443;
                num_b = p_b887;
            end
            svpd_pkg::SEC_1: begin
                num_a = p_a768 + p_b443;
                num_b = p_b443 - p_a768;
            end
            svpd_pkg::SEC_2: begin
                num_a = -p_a768 - p_b443;
                num_b = p_b887;
            end
            svpd_pkg::SEC_3: begin
                num_a = p_b443 - p_a768;
                num_b = -p_b887;
            end
            svpd_pkg::SEC_4: begin
                num_a = p_a768 - p_b443;
                num_b = -p_a768 - p_b443;
            end
            default: begin
                num_a = p_a768 + p_b443;
                num_b = -p_b887;
            end
        endcase
    end

    // Divide by the period, truncating toward zero: bias negatives first
    assign adj_a = num_a + (num_a[PW-1] ? PW'(svpd_pkg::PERIOD - 1) : '0);
    assign adj_b = num_b + (num_b[PW-1] ? PW'(svpd_pkg::PERIOD - 1) : '0);
    assign quo_a = adj_a >>> svpd_pkg::PERIOD_LOG2;
    assign quo_b = adj_b >>> svpd_pkg::PERIOD_LOG2;
    assign o_ta  = quo_a[TW-1:0];
    assign o_tb  = quo_b[TW-1:0];

endmodule

/* src/svpd_compare.sv */
// ----------------------------------------------------------------------------
// svpd_compare: centred phase compare values
// Splits the zero time into two halves and stacks the active times on the
// first half, in the phase order that the sector gives.
// ----------------------------------------------------------------------------
module svpd_compare #(
    parameter int TW = 14,
    parameter int CW = 18
) (
    input  svpd_pkg::t_sector                 i_sector,
    input  logic signed [TW-1:0]              i_ta,
    input  logic signed [TW-1:0]              i_tb,
    output logic [svpd_pkg::OUT_W-1:0]        o_cmp_u,
    output logic [svpd_pkg::OUT_W-1:0]        o_cmp_v,
    output logic [svpd_pkg::OUT_W-1:0]        o_cmp_w
);

    logic signed [CW-1:0] ta_x;
    logic signed [CW-1:0] tb_x;
    logic signed [CW-1:0] t_zero;
    logic signed [CW-1:0] t_half;
    logic signed [CW-1:0] step_1;
    logic signed [CW-1:0] step_2;
    logic signed [CW-1:0] lvl_0;
    logic signed [CW-1:0] lvl_1;
    logic signed [CW-1:0] lvl_2;
    logic                 a_first;

    assign ta_x = CW'(i_ta);
    assign tb_x = CW'(i_tb);

    // Zero time and its half, truncated toward zero
    assign t_zero = CW'(svpd_pkg::PERIOD) - ta_x - tb_x;
    assign t_half = (t_zero + (t_zero[CW-1] ? CW'(1) : CW'(0))) >>> 1;

    // Sectors 0 and 5 stack ta first, the others tb first
    assign a_first = (i_sector == svpd_pkg::SEC_0) || (i_sector == svpd_pkg::SEC_5);
    assign step_1  = a_first ? ta_x : tb_x;
    assign step_2  = a_first ? tb_x : ta_x;
    assign lvl_0   = t_half;
    assign lvl_1   = t_half + step_1;
    assign lvl_2   = lvl_1 + step_2;

    // Route the three levels to the phases
    always_comb begin
        case (i_sector)
            svpd_pkg::SEC_0: begin
                o_cmp_u = lvl_0[svpd_pkg::OUT_W-1:0];
                o_cmp_v = lvl_1[svpd_pkg::OUT_W-1:0];
                o_cmp_w = lvl_2[svpd_pkg::OUT_W-1:0];
            end
            svpd_pkg::SEC_1: begin
                o_cmp_v = lvl_0[svpd_pkg::OUT_W-1:0];
                o_cmp_u = lvl_1[svpd_pkg::OUT_W-1:0];
                o_cmp_w = lvl_2[svpd_pkg::OUT_W-1:0];
            end
            svpd_pkg::SEC_2: begin
                o_cmp_v = lvl_0[svpd_pkg::OUT_W-1:0];
                o_cmp_w = lvl_1[svpd_pkg::OUT_W-1:0];
                o_cmp_u = lvl_2[svpd_pkg::OUT_W-1:0];
            end
            svpd_pkg::SEC_3: begin
                o_cmp_w = lvl_0[svpd_pkg::OUT_W-1:0];
                o_cmp_v = lvl_1[svpd_pkg::OUT_W-1:0];
                o_cmp_u = lvl_2[svpd_pkg::OUT_W-1:0];
            end
            svpd_pkg::SEC_4: begin
                o_cmp_w = lvl_0[svpd_pkg::OUT_W-1:0];
                o_cmp_u = lvl_1[svpd_pkg::OUT_W-1:0];
                o_cmp_v = lvl_2[svpd_pkg::OUT_W-1:0];
            end
            default: begin
                o_cmp_u = lvl_0[svpd_pkg::OUT_W-1:0];
                o_cmp_w = lvl_1[svpd_pkg::OUT_W-1:0];
                o_cmp_v = lvl_2[svpd_pkg::OUT_W-1:0];
            end
        endcase
    end

endmodule
